@@ hw/rtl/dihedral_angle_from_four_points_assert.svh @@
// ----------------------------------------------------------------------------
// Dihedral angle assertion macros
// Shared property wrappers, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DIHEDRAL_ANGLE_FROM_FOUR_POINTS_ASSERT_SVH
`define DIHEDRAL_ANGLE_FROM_FOUR_POINTS_ASSERT_SVH

// same-cycle implication
`define DAFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DAFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dafp_pkg.sv @@
// ----------------------------------------------------------------------------
// Dihedral angle package
// Widths, constants and stage payload types shared by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dafp_pkg;

    localparam int COORD_W  = 21;
    localparam int DIFF_W   = 22;
    localparam int PROD_W   = 44;
    localparam int CROSS_W  = 45;
    localparam int DL_W     = 22;
    localparam int XP_W     = 68;
    localparam int X_W      = 92;
    localparam int P_W      = 69;
    localparam int K_W      = 46;
    localparam int T_W      = 5;
    localparam int T_MAX    = 30;
    localparam int SQ_IN_W  = 62;
    localparam int SQ_RW    = 64;
    localparam int SQ_ITERS = 32;
    localparam int SQ_PER   = 4;
    localparam int SQS      = 8;
    localparam int Q_W      = 31;
    localparam int PCH_W    = 23;
    localparam int YP_W     = 54;
    localparam int Y_W      = 100;
    localparam int XS_W     = 122;
    localparam int OR_W     = 128;
    localparam int GRP      = 16;
    localparam int NORM_W   = 40;
    localparam int SH_W     = 7;
    localparam int CW       = 43;
    localparam int ZW       = 25;
    localparam int STEPS    = 23;
    localparam int STEP_PER = 3;
    localparam int CS       = 8;
    localparam int ANG_W    = 16;
    localparam int AQ_W     = 15;
    localparam int ROUND_SH = 9;
    localparam int ROUND_HALF  = 256;
    localparam int HALF_TURN_Q = 23040;
    localparam int Z_90     = 90 * 65536;
    localparam int Z_180    = 180 * 65536;

    localparam int STEP_ANGLE [STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
    };

    typedef struct packed {
        logic degen;
        logic ple0;
        logic xneg;
    } flags_t;

    typedef struct packed {
        flags_t           f;
        logic [X_W-1:0]   xmag;
        logic [P_W-1:0]   pmag;
        logic [K_W-1:0]   kk;
    } front_t;

    typedef struct packed {
        flags_t            f;
        logic [NORM_W-1:0] xs;
        logic [NORM_W-1:0] ys;
    } norm_t;

endpackage

`default_nettype wire

@@ hw/rtl/dafp_in_if.sv @@
// ----------------------------------------------------------------------------
// Point quadruple channel
// Valid/ready channel carrying the four input points of one item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dafp_in_if import dafp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] i_x;
    logic signed [COORD_W-1:0] i_y;
    logic signed [COORD_W-1:0] i_z;
    logic signed [COORD_W-1:0] j_x;
    logic signed [COORD_W-1:0] j_y;
    logic signed [COORD_W-1:0] j_z;
    logic signed [COORD_W-1:0] k_x;
    logic signed [COORD_W-1:0] k_y;
    logic signed [COORD_W-1:0] k_z;
    logic signed [COORD_W-1:0] l_x;
    logic signed [COORD_W-1:0] l_y;
    logic signed [COORD_W-1:0] l_z;

    modport source (
        output valid, i_x, i_y, i_z, j_x, j_y, j_z, k_x, k_y, k_z, l_x, l_y, l_z,
        input  ready
    );
    modport sink (
        input  valid, i_x, i_y, i_z, j_x, j_y, j_z, k_x, k_y, k_z, l_x, l_y, l_z,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/dafp_out_if.sv @@
// ----------------------------------------------------------------------------
// Angle result channel
// Valid/ready channel carrying one dihedral angle item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dafp_out_if import dafp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] angle_out;
    logic                    degenerate;

    modport source (output valid, angle_out, degenerate, input ready);
    modport sink   (input valid, angle_out, degenerate, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dihedral_angle_from_four_points.sv @@
// ----------------------------------------------------------------------------
// Dihedral angle from four points
// Top level: front end, scaling/normalization and CORDIC pipelines.
// ----------------------------------------------------------------------------
// Computes the signed dihedral angle of points i, j, k, l (1/1024 angstrom)
// in 1/128 degree, with a flag for a zero-length plane normal. Fully
// pipelined: one item enters per cycle unless the output stalls, through 7
// front-end stages, 17 scaling stages dominated by the 8-stage square root
// and 10 CORDIC stages. Each stage has its own valid bit and a stalled output
// only holds the stages that are full, so bubbles are filled while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module dihedral_angle_from_four_points import dafp_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dafp_in_if.sink     pts,
    dafp_out_if.source  angle
);

    logic   fr_valid;
    logic   fr_ready;
    front_t fr_data;
    logic   nm_valid;
    logic   nm_ready;
    norm_t  nm_data;

    dafp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pts       (pts),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_data  (fr_data)
    );

    dafp_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (nm_valid),
        .out_ready (nm_ready),
        .out_data  (nm_data)
    );

    dafp_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (nm_valid),
        .in_ready (nm_ready),
        .in_data  (nm_data),
        .angle    (angle)
    );

endmodule

`default_nettype wire

@@ hw/rtl/dafp_front.sv @@
// ----------------------------------------------------------------------------
// Dihedral front end
// Differences, cross products, dot products X and P, and |k-j|^2.
// Seven stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dafp_front import dafp_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dafp_in_if.sink     pts,
    output logic        out_valid,
    input  wire logic   out_ready,
    output front_t      out_data
);

    localparam int N = 7;

    logic [N-1:0] v_reg;
    logic [N-1:0] adv;

    logic signed [DIFF_W-1:0]  a_reg [3];
    logic signed [DIFF_W-1:0]  b_reg [3];
    logic signed [DIFF_W-1:0]  c_reg [3];
    logic signed [PROD_W-1:0]  dm_reg [6];
    logic signed [PROD_W-1:0]  gm_reg [6];
    logic signed [PROD_W-1:0]  sq_reg [3];
    logic signed [DIFF_W-1:0]  c2_reg [3];
    logic signed [CROSS_W-1:0] d_reg [3];
    logic signed [CROSS_W-1:0] g_reg [3];
    logic signed [DIFF_W-1:0]  c3_reg [3];
    logic [K_W-1:0]            kk3_reg;
    logic signed [XP_W-1:0]    xl_reg [3];
    logic signed [XP_W-1:0]    xh_reg [3];
    logic signed [P_W-1:0]     pp_reg [3];
    logic                      deg4_reg;
    logic [K_W-1:0]            kk4_reg;
    logic signed [X_W-1:0]     xc_reg [3];
    logic signed [P_W-1:0]     p5_reg;
    logic                      deg5_reg;
    logic [K_W-1:0]            kk5_reg;
    logic signed [X_W-1:0]     x6_reg;
    logic signed [P_W-1:0]     p6_reg;
    logic                      deg6_reg;
    logic [K_W-1:0]            kk6_reg;
    front_t                    o_reg;

    always_comb
    begin
        adv[N-1] = !v_reg[N-1] || out_ready;
        for (int s = N - 2; s >= 0; s--)
        begin
            adv[s] = !v_reg[s] || adv[s+1];
        end
    end

    assign pts.ready = adv[0];
    assign out_valid = v_reg[N-1];
    assign out_data  = o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= pts.valid;
            end
            for (int s = 1; s < N; s++)
            begin
                if (adv[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a_reg[0] <= DIFF_W'(pts.i_x) - DIFF_W'(pts.j_x);
            a_reg[1] <= DIFF_W'(pts.i_y) - DIFF_W'(pts.j_y);
            a_reg[2] <= DIFF_W'(pts.i_z) - DIFF_W'(pts.j_z);
            b_reg[0] <= DIFF_W'(pts.k_x) - DIFF_W'(pts.j_x);
            b_reg[1] <= DIFF_W'(pts.k_y) - DIFF_W'(pts.j_y);
            b_reg[2] <= DIFF_W'(pts.k_z) - DIFF_W'(pts.j_z);
            c_reg[0] <= DIFF_W'(pts.k_x) - DIFF_W'(pts.l_x);
            c_reg[1] <= DIFF_W'(pts.k_y) - DIFF_W'(pts.l_y);
            c_reg[2] <= DIFF_W'(pts.k_z) - DIFF_W'(pts.l_z);
        end
        if (adv[1])
        begin
            dm_reg[0] <= a_reg[1] * b_reg[2];
            dm_reg[1] <= a_reg[2] * b_reg[1];
            dm_reg[2] <= a_reg[2] * b_reg[0];
            dm_reg[3] <= a_reg[0] * b_reg[2];
            dm_reg[4] <= a_reg[0] * b_reg[1];
            dm_reg[5] <= a_reg[1] * b_reg[0];
            gm_reg[0] <= b_reg[2] * c_reg[1];
            gm_reg[1] <= b_reg[1] * c_reg[2];
            gm_reg[2] <= b_reg[0] * c_reg[2];
            gm_reg[3] <= b_reg[2] * c_reg[0];
            gm_reg[4] <= b_reg[1] * c_reg[0];
            gm_reg[5] <= b_reg[0] * c_reg[1];
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= b_reg[i] * b_reg[i];
                c2_reg[i] <= c_reg[i];
            end
        end
        if (adv[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i]  <= CROSS_W'(dm_reg[2*i]) - CROSS_W'(dm_reg[2*i+1]);
                g_reg[i]  <= CROSS_W'(gm_reg[2*i]) - CROSS_W'(gm_reg[2*i+1]);
                c3_reg[i] <= c2_reg[i];
            end
            kk3_reg <= K_W'($unsigned(sq_reg[0])) + K_W'($unsigned(sq_reg[1]))
                     + K_W'($unsigned(sq_reg[2]));
        end
        if (adv[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                xl_reg[i] <= $signed({1'b0, d_reg[i][DL_W-1:0]}) * g_reg[i];
                xh_reg[i] <= $signed(d_reg[i][CROSS_W-1:DL_W]) * g_reg[i];
                pp_reg[i] <= d_reg[i] * c3_reg[i];
            end
            deg4_reg <= ((d_reg[0] == '0) && (d_reg[1] == '0) && (d_reg[2] == '0))
                     || ((g_reg[0] == '0) && (g_reg[1] == '0) && (g_reg[2] == '0));
            kk4_reg  <= kk3_reg;
        end
        if (adv[4])
        begin
            for (int i = 0; i < 3; i++)
            begin
                xc_reg[i] <= (X_W'(xh_reg[i]) <<< DL_W) + X_W'(xl_reg[i]);
            end
            p5_reg   <= pp_reg[0] + pp_reg[1] + pp_reg[2];
            deg5_reg <= deg4_reg;
            kk5_reg  <= kk4_reg;
        end
        if (adv[5])
        begin
            x6_reg   <= xc_reg[0] + xc_reg[1] + xc_reg[2];
            p6_reg   <= p5_reg;
            deg6_reg <= deg5_reg;
            kk6_reg  <= kk5_reg;
        end
        if (adv[6])
        begin
            o_reg.f.degen <= deg6_reg;
            o_reg.f.ple0  <= p6_reg[P_W-1] || (p6_reg == '0);
            o_reg.f.xneg  <= x6_reg[X_W-1];
            o_reg.xmag    <= x6_reg[X_W-1] ? $unsigned(-x6_reg) : $unsigned(x6_reg);
            o_reg.pmag    <= p6_reg[P_W-1] ? $unsigned(-p6_reg) : $unsigned(p6_reg);
            o_reg.kk      <= kk6_reg;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dafp_scale.sv @@
// ----------------------------------------------------------------------------
// Dihedral scaling
// Scale exponent t, pipelined square root of |k-j|^2 * 4^t, Y = q*|P|,
// and common right shift of both vector components below 2^40.
// Seventeen stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dafp_scale import dafp_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  front_t      in_data,
    output logic        out_valid,
    input  wire logic   out_ready,
    output norm_t       out_data
);

    localparam int S_T  = 0;
    localparam int S_V  = 1;
    localparam int S_SQ = 2;
    localparam int S_M1 = S_SQ + SQS;
    localparam int S_M2 = S_M1 + 1;
    localparam int S_N1 = S_M2 + 1;
    localparam int S_N2 = S_N1 + 1;
    localparam int S_N3 = S_N2 + 1;
    localparam int S_N4 = S_N3 + 1;
    localparam int S_N5 = S_N4 + 1;
    localparam int N    = S_N5 + 1;

    logic [N-1:0] v_reg;
    logic [N-1:0] adv;

    front_t            f0_reg;
    logic [T_W-1:0]    t0_reg;
    front_t            f1_reg;
    logic [T_W-1:0]    t1_reg;
    logic [SQ_RW-1:0]  v1_reg;
    front_t            fs_reg  [SQS];
    logic [T_W-1:0]    ts_reg  [SQS];
    logic [SQ_RW-1:0]  rem_reg [SQS];
    logic [SQ_RW-1:0]  res_reg [SQS];
    logic [SQ_RW-1:0]  rem_next [SQS];
    logic [SQ_RW-1:0]  res_next [SQS];
    flags_t            fm_reg;
    logic [YP_W-1:0]   ym_reg [3];
    logic [XS_W-1:0]   xs1_reg;
    flags_t            f2_reg;
    logic [Y_W-1:0]    y2_reg;
    logic [XS_W-1:0]   xs2_reg;
    flags_t            f3_reg;
    logic [Y_W-1:0]    y3_reg;
    logic [XS_W-1:0]   xs3_reg;
    logic [GRP-1:0]    gnz_reg;
    flags_t            f4_reg;
    logic [Y_W-1:0]    y4_reg;
    logic [XS_W-1:0]   xs4_reg;
    logic [3:0]        h_reg;
    logic [7:0]        byte_reg;
    flags_t            f5_reg;
    logic [Y_W-1:0]    y5_reg;
    logic [XS_W-1:0]   xs5_reg;
    logic [SH_W-1:0]   sh_reg;
    flags_t            f6_reg;
    logic [Y_W-1:0]    y6_reg;
    logic [XS_W-1:0]   xs6_reg;
    logic [2:0]        shlo_reg;
    norm_t             o_reg;

    logic [5:0]        nbits;
    logic [6:0]        tdiff;
    logic [T_W-1:0]    t_next;
    logic [OR_W-1:0]   w2;
    logic [OR_W-1:0]   w3;
    logic [3:0]        h_next;
    logic [3:0]        lb;
    logic [SH_W-1:0]   bl;
    logic [SH_W-1:0]   sh_next;

    always_comb
    begin
        adv[N-1] = !v_reg[N-1] || out_ready;
        for (int s = N - 2; s >= 0; s--)
        begin
            adv[s] = !v_reg[s] || adv[s+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[N-1];
    assign out_data  = o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < N; s++)
            begin
                if (adv[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // t: largest value up to T_MAX with kk * 4^t below 2^62
    always_comb
    begin
        nbits = '0;
        for (int b = 0; b < K_W; b++)
        begin
            if (in_data.kk[b])
            begin
                nbits = 6'(b + 1);
            end
        end
        tdiff  = 7'(SQ_IN_W) - {1'b0, nbits};
        t_next = (tdiff[6:1] > 6'(T_MAX)) ? T_W'(T_MAX) : tdiff[T_W:1];
    end

    // restoring square root, SQ_PER iterations per stage
    always_comb
    begin
        logic [SQ_RW-1:0] rem_w;
        logic [SQ_RW-1:0] res_w;
        logic [SQ_RW-1:0] bit_w;
        int               it;
        for (int s = 0; s < SQS; s++)
        begin
            if (s == 0)
            begin
                rem_w = v1_reg;
                res_w = '0;
            end
            else
            begin
                rem_w = rem_reg[s-1];
                res_w = res_reg[s-1];
            end
            for (int j = 0; j < SQ_PER; j++)
            begin
                it = s * SQ_PER + j;
                if (it < SQ_ITERS)
                begin
                    bit_w = SQ_RW'(1) << (SQ_IN_W - 2 * it);
                    if (rem_w >= res_w + bit_w)
                    begin
                        rem_w = rem_w - (res_w + bit_w);
                        res_w = (res_w >> 1) + bit_w;
                    end
                    else
                    begin
                        res_w = res_w >> 1;
                    end
                end
            end
            rem_next[s] = rem_w;
            res_next[s] = res_w;
        end
    end

    // leading-one search over the OR of both components
    always_comb
    begin
        w2 = OR_W'(XS_W'(y2_reg) | xs2_reg);
        w3 = OR_W'(XS_W'(y3_reg) | xs3_reg);
        h_next = '0;
        for (int g = 0; g < GRP; g++)
        begin
            if (gnz_reg[g])
            begin
                h_next = 4'(g);
            end
        end
        lb = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (byte_reg[b])
            begin
                lb = 4'(b + 1);
            end
        end
        bl      = {h_reg, 3'b000} + SH_W'(lb);
        sh_next = (bl > SH_W'(NORM_W)) ? bl - SH_W'(NORM_W) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv[S_T])
        begin
            f0_reg <= in_data;
            t0_reg <= t_next;
        end
        if (adv[S_V])
        begin
            f1_reg <= f0_reg;
            t1_reg <= t0_reg;
            v1_reg <= SQ_RW'(f0_reg.kk) << {t0_reg, 1'b0};
        end
        for (int s = 0; s < SQS; s++)
        begin
            if (adv[S_SQ+s])
            begin
                rem_reg[s] <= rem_next[s];
                res_reg[s] <= res_next[s];
                if (s == 0)
                begin
                    fs_reg[s] <= f1_reg;
                    ts_reg[s] <= t1_reg;
                end
                else
                begin
                    fs_reg[s] <= fs_reg[s-1];
                    ts_reg[s] <= ts_reg[s-1];
                end
            end
        end
        if (adv[S_M1])
        begin
            fm_reg  <= fs_reg[SQS-1].f;
            for (int k = 0; k < 3; k++)
            begin
                ym_reg[k] <= YP_W'(fs_reg[SQS-1].pmag[k*PCH_W +: PCH_W])
                           * YP_W'(res_reg[SQS-1][Q_W-1:0]);
            end
            xs1_reg <= XS_W'(fs_reg[SQS-1].xmag) << ts_reg[SQS-1];
        end
        if (adv[S_M2])
        begin
            f2_reg  <= fm_reg;
            y2_reg  <= Y_W'(ym_reg[0]) + (Y_W'(ym_reg[1]) << PCH_W)
                     + (Y_W'(ym_reg[2]) << (2 * PCH_W));
            xs2_reg <= xs1_reg;
        end
        if (adv[S_N1])
        begin
            f3_reg  <= f2_reg;
            y3_reg  <= y2_reg;
            xs3_reg <= xs2_reg;
            for (int g = 0; g < GRP; g++)
            begin
                gnz_reg[g] <= |w2[g*8 +: 8];
            end
        end
        if (adv[S_N2])
        begin
            f4_reg   <= f3_reg;
            y4_reg   <= y3_reg;
            xs4_reg  <= xs3_reg;
            h_reg    <= h_next;
            byte_reg <= w3[{h_next, 3'b000} +: 8];
        end
        if (adv[S_N3])
        begin
            f5_reg  <= f4_reg;
            y5_reg  <= y4_reg;
            xs5_reg <= xs4_reg;
            sh_reg  <= sh_next;
        end
        if (adv[S_N4])
        begin
            f6_reg   <= f5_reg;
            y6_reg   <= y5_reg >> {sh_reg[SH_W-1:3], 3'b000};
            xs6_reg  <= xs5_reg >> {sh_reg[SH_W-1:3], 3'b000};
            shlo_reg <= sh_reg[2:0];
        end
        if (adv[S_N5])
        begin
            o_reg.f  <= f6_reg;
            o_reg.ys <= NORM_W'(y6_reg >> shlo_reg);
            o_reg.xs <= NORM_W'(xs6_reg >> shlo_reg);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dafp_cordic.sv @@
// ----------------------------------------------------------------------------
// Dihedral CORDIC
// Quadrant pre-rotation, 23 vectoring steps three per stage, then clamp,
// rounding to 1/128 degree and the signed branch selection. Ten stages.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dihedral_angle_from_four_points_assert.svh"

module dafp_cordic import dafp_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  norm_t       in_data,
    dafp_out_if.source  angle
);

    localparam int N = CS + 2;

    logic [N-1:0] v_reg;
    logic [N-1:0] adv;

    logic signed [CW-1:0] x_reg [CS+1];
    logic signed [CW-1:0] y_reg [CS+1];
    logic signed [ZW-1:0] z_reg [CS+1];
    flags_t               f_reg [CS+1];
    logic signed [CW-1:0] x_next [CS+1];
    logic signed [CW-1:0] y_next [CS+1];
    logic signed [ZW-1:0] z_next [CS+1];
    logic signed [ANG_W-1:0] ang_reg;
    logic                    deg_reg;

    logic signed [ZW-1:0]    zc;
    logic signed [ZW-1:0]    zr;
    logic [AQ_W-1:0]         aq;
    logic signed [ANG_W-1:0] ang_next;

    always_comb
    begin
        adv[N-1] = !v_reg[N-1] || angle.ready;
        for (int s = N - 2; s >= 0; s--)
        begin
            adv[s] = !v_reg[s] || adv[s+1];
        end
    end

    assign in_ready         = adv[0];
    assign angle.valid      = v_reg[N-1];
    assign angle.angle_out  = ang_reg;
    assign angle.degenerate = deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < N; s++)
            begin
                if (adv[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_comb
    begin
        logic signed [CW-1:0] xw;
        logic signed [CW-1:0] yw;
        logic signed [ZW-1:0] zw;
        logic signed [CW-1:0] xsh;
        logic signed [CW-1:0] ysh;
        int                   it;
        // pre-rotation by -90 degrees for a negative x
        if (in_data.f.xneg && (in_data.xs != '0))
        begin
            x_next[0] = $signed(CW'(in_data.ys));
            y_next[0] = $signed(CW'(in_data.xs));
            z_next[0] = ZW'(Z_90);
        end
        else
        begin
            x_next[0] = in_data.f.xneg ? '0 : $signed(CW'(in_data.xs));
            y_next[0] = $signed(CW'(in_data.ys));
            z_next[0] = '0;
        end
        for (int s = 1; s <= CS; s++)
        begin
            xw = x_reg[s-1];
            yw = y_reg[s-1];
            zw = z_reg[s-1];
            for (int j = 0; j < STEP_PER; j++)
            begin
                it = (s - 1) * STEP_PER + j;
                if (it < STEPS)
                begin
                    xsh = xw >>> it;
                    ysh = yw >>> it;
                    if (yw > 0)
                    begin
                        xw = xw + ysh;
                        yw = yw - xsh;
                        zw = zw + ZW'(STEP_ANGLE[it]);
                    end
                    else
                    begin
                        xw = xw - ysh;
                        yw = yw + xsh;
                        zw = zw - ZW'(STEP_ANGLE[it]);
                    end
                end
            end
            x_next[s] = xw;
            y_next[s] = yw;
            z_next[s] = zw;
        end
    end

    always_comb
    begin
        zc = z_reg[CS];
        if (zc < 0)
        begin
            zc = '0;
        end
        if (zc > ZW'(Z_180))
        begin
            zc = ZW'(Z_180);
        end
        zr = zc + ZW'(ROUND_HALF);
        aq = zr[ROUND_SH +: AQ_W];
        if (f_reg[CS].ple0 && (aq != '0))
        begin
            ang_next = ANG_W'(HALF_TURN_Q) - $signed({1'b0, aq});
        end
        else
        begin
            ang_next = $signed({1'b0, aq}) - ANG_W'(HALF_TURN_Q);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= CS; s++)
        begin
            if (adv[s])
            begin
                x_reg[s] <= x_next[s];
                y_reg[s] <= y_next[s];
                z_reg[s] <= z_next[s];
                if (s == 0)
                begin
                    f_reg[s] <= in_data.f;
                end
                else
                begin
                    f_reg[s] <= f_reg[s-1];
                end
            end
        end
        if (adv[N-1])
        begin
            deg_reg <= f_reg[CS].degen;
            ang_reg <= f_reg[CS].degen ? '0 : ang_next;
        end
    end

    `DAFP_ASSERT_IMP(a_degen_zero, v_reg[N-1] && deg_reg, ang_reg == '0,
        "degenerate item with nonzero angle")
    `DAFP_ASSERT_IMP(a_angle_range, v_reg[N-1] && !deg_reg,
        (ang_reg >= -16'sd23040) && (ang_reg <= 16'sd23040), "angle out of range")
    `DAFP_ASSERT_IMP(a_prerot_pos, v_reg[0], !x_reg[0][CW-1],
        "negative x after pre-rotation")
    `DAFP_ASSERT_NXT(a_step_hold, v_reg[N-1] && !angle.ready,
        v_reg[N-1] && $stable(ang_reg) && $stable(deg_reg), "result lost during stall")

endmodule

`default_nettype wire

@@ tb/dafp_checker.sv @@
// ----------------------------------------------------------------------------
// Dihedral angle checker
// Watches both channels, predicts each angle item with a bit-exact integer
// model and compares results in order. Hands its failure count to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dafp_checker import dafp_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    dafp_in_if.sink   pts,
    dafp_out_if.sink  angle,
    output int        fails,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [ANG_W-1:0] ang;
        logic                    degen;
    } angle_res_t;

    angle_res_t angle_q[$];

    function automatic longint floor_sh(longint v, int i);
        return v >>> i;
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic angle_res_t torsion(
        input longint ix, iy, iz, jx, jy, jz, kx, ky, kz, lx, ly, lz);
        angle_res_t r;
        longint ax, ay, az, bx, by, bz, cx, cy, cz;
        longint dx, dy, dz, gx, gy, gz;
        logic signed [127:0] xw, pw;
        logic [127:0] xm, pm, yw, xsw;
        logic ple0, xneg;
        logic [63:0] kk, q;
        int t;
        longint x, y, z, tmp, xs, ys, aq;
        ax = ix - jx; ay = iy - jy; az = iz - jz;
        bx = kx - jx; by = ky - jy; bz = kz - jz;
        cx = kx - lx; cy = ky - ly; cz = kz - lz;
        dx = ay * bz - az * by; dy = az * bx - ax * bz; dz = ax * by - ay * bx;
        gx = bz * cy - by * cz; gy = bx * cz - bz * cx; gz = by * cx - bx * cy;
        r.ang = 0;
        r.degen = 1'b1;
        if ((dx == 0 && dy == 0 && dz == 0) || (gx == 0 && gy == 0 && gz == 0))
            return r;
        xw = 128'(signed'(dx)) * 128'(signed'(gx)) + 128'(signed'(dy)) * 128'(signed'(gy))
           + 128'(signed'(dz)) * 128'(signed'(gz));
        pw = 128'(signed'(dx)) * 128'(signed'(cx)) + 128'(signed'(dy)) * 128'(signed'(cy))
           + 128'(signed'(dz)) * 128'(signed'(cz));
        ple0 = (pw <= 0);
        pm = (pw < 0) ? -pw : pw;
        xneg = (xw < 0);
        xm = xneg ? -xw : xw;
        kk = bx * bx + by * by + bz * bz;
        t = 0;
        while (t < 30 && kk < (64'd1 << (60 - 2 * t))) t++;
        q = isqrt(kk << (2 * t));
        yw = pm * {64'd0, q};
        xsw = xm << t;
        while (yw >= 128'h100_0000_0000 || xsw >= 128'h100_0000_0000) begin
            yw = yw >> 1;
            xsw = xsw >> 1;
        end
        x = longint'(xsw[63:0]);
        if (xneg) x = -x;
        y = longint'(yw[63:0]);
        z = 0;
        if (x < 0) begin
            tmp = x; x = y; y = -tmp; z = Z_90;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = floor_sh(x, i);
            ys = floor_sh(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += STEP_ANGLE[i];
            end else begin
                x -= ys; y += xs; z -= STEP_ANGLE[i];
            end
        end
        if (z < 0) z = 0;
        if (z > Z_180) z = Z_180;
        aq = (z + ROUND_HALF) >>> ROUND_SH;
        r.ang = (ple0 && aq > 0) ? ANG_W'(HALF_TURN_Q - aq) : ANG_W'(aq - HALF_TURN_Q);
        r.degen = 1'b0;
        return r;
    endfunction

    assign pending = angle_q.size();

    initial fails = 0;

    always @(posedge clk) begin
        angle_res_t e;
        if (rst_n && pts.valid && pts.ready)
            angle_q.push_back(torsion(pts.i_x, pts.i_y, pts.i_z, pts.j_x, pts.j_y,
                pts.j_z, pts.k_x, pts.k_y, pts.k_z, pts.l_x, pts.l_y, pts.l_z));
        if (rst_n && angle.valid && angle.ready) begin
            if (angle_q.size() == 0) begin
                $error("unexpected angle item");
                fails++;
            end else begin
                e = angle_q.pop_front();
                if (angle.angle_out !== e.ang) begin
                    $error("angle_out exp %0d got %0d", e.ang, angle.angle_out);
                    fails++;
                end
                if (angle.degenerate !== e.degen) begin
                    $error("degenerate exp %0d got %0d", e.degen, angle.degenerate);
                    fails++;
                end
            end
        end
    end
endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Dihedral angle testbench
// Directed corner quadruples then random geometry, with random idling on
// both channels and one long output hold-off; checking is in the checker.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dafp_pkg::*;

    localparam int N_RAND   = 1200;
    localparam int LATENCY  = 34;
    localparam int LIMIT    = 400000;
    localparam int C_MAX    = 1048575;
    localparam int C_MIN    = -1048576;

    logic clk = 0;
    logic rst_n = 0;
    int   fails;
    int   pending;
    int   cycles = 0;
    bit   calm = 0;
    bit   hold = 0;
    bit   feeding_done = 0;

    dafp_in_if  pts ();
    dafp_out_if angle ();

    dihedral_angle_from_four_points dut (.clk(clk), .rst_n(rst_n), .pts(pts), .angle(angle));
    dafp_checker chk (.clk(clk), .rst_n(rst_n), .pts(pts), .angle(angle),
        .fails(fails), .pending(pending));

    always #5 clk = ~clk;

    typedef logic signed [COORD_W-1:0] coord_t;
    coord_t pt [12];

    function automatic coord_t rnd_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(0, 8192)) - 4096);
            default: return ($urandom_range(0, 1)) ? coord_t'(C_MAX) : coord_t'(C_MIN);
        endcase
    endfunction

    task automatic send();
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            pts.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pts.valid <= 1'b1;
        {pts.i_x, pts.i_y, pts.i_z} <= {pt[0], pt[1], pt[2]};
        {pts.j_x, pts.j_y, pts.j_z} <= {pt[3], pt[4], pt[5]};
        {pts.k_x, pts.k_y, pts.k_z} <= {pt[6], pt[7], pt[8]};
        {pts.l_x, pts.l_y, pts.l_z} <= {pt[9], pt[10], pt[11]};
        do @(posedge clk); while (!pts.ready);
    endtask

    task automatic send_geom(int mode);
        for (int n = 0; n < 12; n++) pt[n] = rnd_coord(mode);
        case ($urandom_range(0, 9))
            0: for (int n = 0; n < 3; n++) pt[6 + n] = pt[3 + n];
            1: for (int n = 0; n < 3; n++) pt[n] = pt[3 + n];
            2: for (int n = 0; n < 3; n++) pt[9 + n] = pt[6 + n];
            3: for (int n = 0; n < 3; n++) pt[9 + n] = pt[n] + pt[6 + n] - pt[3 + n];
            4: for (int n = 0; n < 3; n++) pt[9 + n] = pt[n];
            default: ;
        endcase
        send();
    endtask

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int gap;
        angle.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold) angle.ready <= 1'b0;
            else if (!calm && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 5);
                angle.ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end else angle.ready <= 1'b1;
        end
    end

    initial begin
        pts.valid = 1'b0;
        {pts.i_x, pts.i_y, pts.i_z, pts.j_x, pts.j_y, pts.j_z} = '0;
        {pts.k_x, pts.k_y, pts.k_z, pts.l_x, pts.l_y, pts.l_z} = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: right angle, planar cis and trans, degenerate, extremes
        pt = '{1024, 0, 0, 0, 0, 0, 0, 1024, 0, 0, 1024, 1024};
        send();
        pt = '{1024, 0, 0, 0, 0, 0, 0, 1024, 0, 1024, 1024, 0};
        send();
        pt = '{1024, 0, 0, 0, 0, 0, 0, 1024, 0, -1024, 1024, 0};
        send();
        pt = '{1024, 0, 0, 0, 0, 0, 0, 1024, 0, 0, 1024, -1024};
        send();
        pt = '{1024, 0, 0, 0, 0, 0, 0, 0, 0, 5, 6, 7};
        send();
        pt = '{0, 2048, 0, 0, 0, 0, 0, 1024, 0, 9, 1, 3};
        send();
        pt = '{1, 2, 3, 0, 0, 0, 0, 0, 1, 4, 4, 1};
        send();
        pt = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send();
        pt = '{C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
               C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX};
        send();
        pt = '{C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN,
               C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN};
        send();
        pt = '{C_MAX, 0, 0, C_MIN, 0, 0, 0, C_MAX, 0, 0, 0, C_MIN};
        send();
        pt = '{1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 1};
        send();
        pt = '{1, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1, -1};
        send();
        for (int n = 0; n < 6; n++) send_geom(2);

        for (int n = 0; n < N_RAND; n++) begin
            if (n == 300) fork
                begin
                    hold = 1;
                    repeat (200) @(posedge clk);
                    hold = 0;
                end
            join_none
            if (n == N_RAND - 150) calm = 1;
            send_geom($urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 4) == 0 ? 2 : 1));
        end
        pts.valid <= 1'b0;
        wait (pending == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

`default_nettype wire
